// File: src/kcr_pkg.sv
// Shared types and constants of the replicated-border kernel convolution block.
package kcr_pkg;

  localparam int unsigned DIM_W  = 11;  // image width and height registers
  localparam int unsigned KS_W   = 3;   // kernel size register
  localparam int unsigned COEF_W = 16;  // Q4.12 coefficient
  localparam int unsigned PIX_W  = 8;   // greyscale pixel
  localparam int unsigned POS_W  = 10;  // result row and column
  localparam int unsigned CIDX_W = 6;   // coefficient index field
  localparam int unsigned FRAC_W = 12;  // fractional bits of a coefficient
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KSIZE  = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    cmd_e                      command;
    logic [CIDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic [PIX_W-1:0]          pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             clipped;
    logic             last;
  } out_item_t;

endpackage

// File: src/kcr_stream_if.sv
// Valid/ready stream interfaces for input items and result items.
interface kcr_in_if;
  logic              valid;
  logic              ready;
  kcr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kcr_out_if;
  logic               valid;
  logic               ready;
  kcr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/kcr_coef_cell.sv
// One cell of the coefficient ring: holds a coefficient, loads or takes its neighbour's.
module kcr_coef_cell (
  input  logic                                clk_i,
  input  logic                                shift_i,
  input  logic                                load_i,
  input  logic signed [kcr_pkg::COEF_W-1:0]   load_val_i,
  input  logic signed [kcr_pkg::COEF_W-1:0]   nb_i,
  output logic signed [kcr_pkg::COEF_W-1:0]   coef_o
);

  logic signed [kcr_pkg::COEF_W-1:0] coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (load_i) begin
      coef_d = load_val_i;
    end else if (shift_i) begin
      coef_d = nb_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

// File: src/kcr_line_mem.sv
// Line store: one write port, one registered read port.
module kcr_line_mem #(
  parameter int unsigned DEPTH = 7168
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH)-1:0]        waddr_i,
  input  logic [kcr_pkg::PIX_W-1:0]       wdata_i,
  input  logic [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [kcr_pkg::PIX_W-1:0]       rdata_o
);

  logic [kcr_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [kcr_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/kcr_mac.sv
// Multiply-accumulate over the window taps, then round half up and saturate.
module kcr_mac #(
  parameter int unsigned ACC_W = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clear_i,
  input  logic                               tap_i,
  input  logic [kcr_pkg::PIX_W-1:0]          pix_i,
  input  logic signed [kcr_pkg::COEF_W-1:0]  coef_i,
  output logic [kcr_pkg::PIX_W-1:0]          pix_o,
  output logic                               clip_o
);

  localparam int unsigned PROD_W = kcr_pkg::PIX_W + kcr_pkg::COEF_W + 1;
  localparam int unsigned Q_W    = ACC_W - kcr_pkg::FRAC_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (kcr_pkg::FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     tap_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  sum;
  logic [Q_W-1:0]           quo;
  logic                     neg, big;

  assign prod_d = $signed({1'b0, pix_i}) * coef_i;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (tap_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= 1'b0;
    end else begin
      tap_q <= tap_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // floor((acc + 2048) / 4096), clamped to the pixel range
  assign sum = acc_q + HALF;
  assign neg = sum[ACC_W-1];
  assign quo = sum[ACC_W-1:kcr_pkg::FRAC_W];
  assign big = !neg && (quo > Q_W'(255));

  always_comb begin
    if (neg) begin
      pix_o = '0;
    end else if (big) begin
      pix_o = '1;
    end else begin
      pix_o = quo[kcr_pkg::PIX_W-1:0];
    end
  end

  assign clip_o = neg || big;

endmodule

// File: src/kernel_convolution_replicate_border.sv
// Streaming KxK convolution of a raster greyscale image with replicated borders.
// Each result runs a full ring turn (ST_RUN), the drain state and the emit state after its
//   item or the previous result of that item; a full output register stalls the emit.
// Items are taken only in ST_IDLE: one that releases nothing leaves the block idle, else
//   the next item waits for all its results, paced by the ring and one line-store read port.
// Reset: control, position and registers (640 x 480, kernel 3) clear at once.
module kernel_convolution_replicate_border #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_KERNEL = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  kcr_in_if.sink                        in_i,
  kcr_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kcr_pkg::APB_AW-1:0]    paddr,
  input  logic [kcr_pkg::APB_DW-1:0]    pwdata,
  output logic [kcr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // Cells in the coefficient ring: one per kernel position.
  localparam int unsigned NCELL  = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned T_W    = $clog2(NCELL + 1);
  localparam int unsigned EW     = kcr_pkg::DIM_W + 3;   // signed position arithmetic
  localparam int unsigned KW     = kcr_pkg::KS_W + 1;
  localparam int unsigned LDEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned LA_W   = $clog2(LDEPTH);
  localparam int unsigned SL_W   = $clog2(MAX_KERNEL + 1);
  localparam int unsigned I_W    = ($clog2(NCELL) > kcr_pkg::CIDX_W) ?
                                   $clog2(NCELL) : kcr_pkg::CIDX_W;
  localparam int unsigned ACC_W  = kcr_pkg::PIX_W + kcr_pkg::COEF_W + 2 + $clog2(NCELL);

  // ---------------------------------------------------------------- registers
  logic [kcr_pkg::DIM_W-1:0] width_q, height_q;
  logic [kcr_pkg::KS_W-1:0]  ksize_q;
  kcr_pkg::reg_e             reg_idx;
  logic                      cfg_wr;

  assign reg_idx = kcr_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= kcr_pkg::DIM_W'(640);
      height_q <= kcr_pkg::DIM_W'(480);
      ksize_q  <= kcr_pkg::KS_W'(3);
    end else if (cfg_wr) begin
      case (reg_idx)
        kcr_pkg::REG_WIDTH:  width_q  <= pwdata[kcr_pkg::DIM_W-1:0];
        kcr_pkg::REG_HEIGHT: height_q <= pwdata[kcr_pkg::DIM_W-1:0];
        kcr_pkg::REG_KSIZE:  ksize_q  <= pwdata[kcr_pkg::KS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kcr_pkg::REG_WIDTH:  prdata = kcr_pkg::APB_DW'(width_q);
      kcr_pkg::REG_HEIGHT: prdata = kcr_pkg::APB_DW'(height_q);
      kcr_pkg::REG_KSIZE:  prdata = kcr_pkg::APB_DW'(ksize_q);
      default:             prdata = '0;
    endcase
  end

  // a write to the width, height or kernel-size register restarts the frame
  logic cfg_hit;
  assign cfg_hit = cfg_wr && (reg_idx != kcr_pkg::REG_NONE);

  // Effective geometry: width and height capped at MAX_WIDTH and MAX_HEIGHT.
  logic [EW-1:0] w_e, h_e, o_e, k_e;
  logic          k_ok;

  assign w_e  = (EW'(width_q) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_q);
  assign h_e  = (EW'(height_q) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(height_q);
  assign k_e  = EW'(ksize_q);
  assign o_e  = EW'(ksize_q >> 1);
  assign k_ok = ksize_q[0] && (k_e <= EW'(MAX_KERNEL)) && (w_e != '0) && (h_e != '0);

  // ---------------------------------------------------------------- control state
  kcr_pkg::state_e state_q, state_d;

  logic [kcr_pkg::DIM_W-1:0] in_row_q, in_row_d, in_col_q, in_col_d;
  logic [SL_W-1:0]           wr_slot_q, wr_slot_d;
  logic [EW-1:0]             row_q, row_d;      // input row of the item being served
  logic [SL_W-1:0]           slot_q, slot_d;    // its line-store slot
  logic [EW-1:0]             r_q, r_d;          // result row
  logic [EW-1:0]             col_q, col_d;      // result column
  logic [EW-1:0]             lastc_q, lastc_d;
  logic [KW-1:0]             kr_q, kr_d, kc_q, kc_d;
  logic [T_W-1:0]            t_q, t_d;
  logic                      dr_q, dr_d;
  logic                      oval_q, oval_d;
  kcr_pkg::out_item_t        odata_q, odata_d;

  logic                      acc_in, act, is_pix, is_fl, has_out, mac_clear, emit;
  logic                      tap;
  logic [EW-1:0]             rr, cc, c1, r1, first_c, last_c;

  logic [kcr_pkg::PIX_W-1:0] res_pix;
  logic                      res_clip;

  assign in_i.ready = (state_q == kcr_pkg::ST_IDLE);
  assign acc_in     = in_i.valid && in_i.ready;

  assign rr     = EW'(in_row_q);
  assign cc     = EW'(in_col_q);
  assign is_pix = (in_i.data.command == kcr_pkg::CMD_PIXEL) && (rr < h_e);
  assign is_fl  = (in_i.data.command == kcr_pkg::CMD_FLUSH) && (rr >= h_e);
  assign act    = acc_in && k_ok && (is_pix || is_fl);
  assign c1     = cc + EW'(1);
  assign r1     = rr + EW'(1);

  // Which result columns this item releases.
  always_comb begin
    has_out = 1'b0;
    first_c = '0;
    last_c  = '0;
    if (rr >= o_e) begin
      if (cc >= o_e) begin
        has_out = 1'b1;
        first_c = cc - o_e;
        last_c  = (cc == w_e - EW'(1)) ? w_e - EW'(1) : cc - o_e;
      end else if (cc == w_e - EW'(1)) begin
        has_out = 1'b1;
        last_c  = w_e - EW'(1);
      end
    end
  end

  // Tap walk: kernel row and column step in flat order, in step with the ring.
  assign tap = (state_q == kcr_pkg::ST_RUN) && (kr_q < KW'(ksize_q));

  assign emit = (state_q == kcr_pkg::ST_EMIT) && (!oval_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    wr_slot_d = wr_slot_q;
    row_d     = row_q;
    slot_d    = slot_q;
    r_d       = r_q;
    col_d     = col_q;
    lastc_d   = lastc_q;
    kr_d      = kr_q;
    kc_d      = kc_q;
    t_d       = t_q;
    dr_d      = dr_q;
    mac_clear = 1'b0;

    case (state_q)
      kcr_pkg::ST_IDLE: begin
        if (act) begin
          // advance the raster position
          if (c1 >= w_e) begin
            in_col_d = '0;
            if (r1 >= h_e + o_e) begin
              in_row_d  = '0;
              wr_slot_d = '0;
            end else begin
              in_row_d  = r1[kcr_pkg::DIM_W-1:0];
              wr_slot_d = (wr_slot_q == SL_W'(MAX_KERNEL - 1)) ? '0 : wr_slot_q + SL_W'(1);
            end
          end else begin
            in_col_d = c1[kcr_pkg::DIM_W-1:0];
          end
          if (has_out) begin
            row_d     = rr;
            slot_d    = wr_slot_q;
            r_d       = rr - o_e;
            col_d     = first_c;
            lastc_d   = last_c;
            kr_d      = '0;
            kc_d      = '0;
            t_d       = '0;
            mac_clear = 1'b1;
            state_d   = kcr_pkg::ST_RUN;
          end
        end
      end
      kcr_pkg::ST_RUN: begin
        if (kr_q < KW'(ksize_q)) begin
          if (kc_q == KW'(ksize_q) - KW'(1)) begin
            kc_d = '0;
            kr_d = kr_q + KW'(1);
          end else begin
            kc_d = kc_q + KW'(1);
          end
        end
        t_d = t_q + T_W'(1);
        if (t_q == T_W'(NCELL - 1)) begin
          dr_d    = 1'b0;
          state_d = kcr_pkg::ST_DRAIN;
        end
      end
      kcr_pkg::ST_DRAIN: begin
        // the drain state lets the read and multiply stages settle
        dr_d = 1'b1;
        if (dr_q) begin
          state_d = kcr_pkg::ST_EMIT;
        end
      end
      kcr_pkg::ST_EMIT: begin
        if (emit) begin
          if (col_q == lastc_q) begin
            state_d = kcr_pkg::ST_IDLE;
          end else begin
            col_d     = col_q + EW'(1);
            kr_d      = '0;
            kc_d      = '0;
            t_d       = '0;
            mac_clear = 1'b1;
            state_d   = kcr_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_d = kcr_pkg::ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      in_row_d  = '0;
      in_col_d  = '0;
      wr_slot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kcr_pkg::ST_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      wr_slot_q <= '0;
      t_q       <= '0;
      kr_q      <= '0;
      kc_q      <= '0;
      dr_q      <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      wr_slot_q <= wr_slot_d;
      t_q       <= t_d;
      kr_q      <= kr_d;
      kc_q      <= kc_d;
      dr_q      <= dr_d;
      oval_q    <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    slot_q  <= slot_d;
    r_q     <= r_d;
    col_q   <= col_d;
    lastc_q <= lastc_d;
    odata_q <= odata_d;
  end

  // ---------------------------------------------------------------- window address
  // Row y and column x clamp to the image; slot of y counts back from the item's row.
  logic signed [EW-1:0] ys, xs;
  logic [EW-1:0]        y_c, x_c, d_e, sl_e;
  logic [LA_W-1:0]      raddr, waddr;

  always_comb begin
    ys = $signed(r_q) + $signed(EW'(kr_q)) - $signed(o_e);
    xs = $signed(col_q) + $signed(EW'(kc_q)) - $signed(o_e);
    if (ys < 0) begin
      y_c = '0;
    end else if (ys > $signed(h_e - EW'(1))) begin
      y_c = h_e - EW'(1);
    end else begin
      y_c = ys;
    end
    if (xs < 0) begin
      x_c = '0;
    end else if (xs > $signed(w_e - EW'(1))) begin
      x_c = w_e - EW'(1);
    end else begin
      x_c = xs;
    end
    d_e  = row_q - y_c;
    sl_e = (EW'(slot_q) >= d_e) ? EW'(slot_q) - d_e : EW'(slot_q) + EW'(MAX_KERNEL) - d_e;
  end

  assign raddr = tap ? LA_W'(sl_e) * LA_W'(MAX_WIDTH) + LA_W'(x_c) : '0;
  assign waddr = LA_W'(wr_slot_q) * LA_W'(MAX_WIDTH) + LA_W'(in_col_q);

  logic [kcr_pkg::PIX_W-1:0] line_rd;

  kcr_line_mem #(
    .DEPTH (LDEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (act && is_pix),
    .waddr_i (waddr),
    .wdata_i (in_i.data.pixel_value),
    .raddr_i (raddr),
    .rdata_o (line_rd)
  );

  // ---------------------------------------------------------------- coefficient ring
  // Cell i holds coefficient i at rest; one full turn per result presents them in
  // flat order at cell 0, matching the tap walk.
  logic signed [kcr_pkg::COEF_W-1:0] ring [NCELL];
  logic                              load_en, ring_shift;
  logic [I_W-1:0]                    idx_ext;

  assign load_en    = acc_in && (in_i.data.command == kcr_pkg::CMD_LOAD);
  assign ring_shift = (state_q == kcr_pkg::ST_RUN);
  assign idx_ext    = I_W'(in_i.data.coef_index);

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    kcr_coef_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ring_shift),
      .load_i     (load_en && (idx_ext == I_W'(i))),
      .load_val_i (in_i.data.coef_value),
      .nb_i       (ring[(i + 1) % NCELL]),
      .coef_o     (ring[i])
    );
  end

  // coefficient and tap flag are registered to line up with the registered line-store read
  logic signed [kcr_pkg::COEF_W-1:0] coef_q;
  logic                              tap_q;

  always_ff @(posedge clk_i) begin
    coef_q <= ring[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= 1'b0;
    end else begin
      tap_q <= tap;
    end
  end

  kcr_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mac_clear),
    .tap_i   (tap_q),
    .pix_i   (line_rd),
    .coef_i  (coef_q),
    .pix_o   (res_pix),
    .clip_o  (res_clip)
  );

  // ---------------------------------------------------------------- result register
  // Holds one result so the next item is taken while it waits for its transfer.
  always_comb begin
    oval_d  = oval_q && !out_o.ready;
    odata_d = odata_q;
    if (emit) begin
      oval_d            = 1'b1;
      odata_d.out_pixel = res_pix;
      odata_d.out_row   = r_q[kcr_pkg::POS_W-1:0];
      odata_d.out_col   = col_q[kcr_pkg::POS_W-1:0];
      odata_d.clipped   = res_clip;
      odata_d.last      = (col_q == lastc_q);
    end
  end

  assign out_o.valid = oval_q;
  assign out_o.data  = odata_q;

endmodule
